@@ rtl/core/shc_pkg.sv @@
// package for the streaming sha-512 core: types, round constants, initial values
// no dependencies
package shc_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } shc_state_t;

    // phases of the finishing sequence
    typedef enum logic [2:0] {
        PH_NONE,
        PH_AFTER_PAD,
        PH_MARKER,
        PH_AFTER_MARK,
        PH_EXTRA,
        PH_FINAL
    } shc_phase_t;

    // datapath command group
    typedef struct packed {
        logic       store_word;   // write input word into the window
        logic       pad_last;     // last word: mask, pad, clear tail
        logic       pad_marker;   // write 0x80 marker at pad position
        logic       clear_win;    // zero whole window
        logic       write_len;    // write length into words 14 and 15
        logic       load_vars;    // copy chain into working vars
        logic       do_round;     // run one round
        logic       add_chain;    // fold working vars into chain
        logic       reload;       // restore initial state
    } shc_cmd_t;

    // datapath status group
    typedef struct packed {
        logic       block_full;   // slot counter wrapped back to zero
        logic       last_round;   // round 79 executing
        logic       pad_over;     // pad position is 128
        logic       need_extra;   // pad position plus one exceeds 112
    } shc_stat_t;

    localparam logic [63:0] INIT_H [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [63:0] ROUND_K [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    localparam logic [6:0] LAST_ROUND = 7'd79;

endpackage

@@ rtl/core/shc_if.sv @@
// handshake channel interfaces for message words and digest words
// depends on nothing
interface shc_msg_if;
    logic        valid;
    logic        ready;
    logic [63:0] message_word;
    logic [3:0]  valid_bytes;
    logic        last_word;
    modport source (output valid, message_word, valid_bytes, last_word, input ready);
    modport sink   (input valid, message_word, valid_bytes, last_word, output ready);
endinterface

interface shc_dig_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_done;
    modport source (output valid, digest_word, word_index, digest_done, input ready);
    modport sink   (input valid, digest_word, word_index, digest_done, output ready);
endinterface

@@ rtl/core/shc_datapath.sv @@
// datapath: message window, round unit, chaining state, byte counter
// depends on shc_pkg
module shc_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  shc_pkg::shc_cmd_t cmd,
    output shc_pkg::shc_stat_t stat,
    input  logic [63:0]      message_word,
    input  logic [3:0]       valid_bytes,
    input  logic [2:0]       emit_index,
    output logic [63:0]      digest_word
);
    import shc_pkg::*;

    logic [63:0] win_reg [16];
    logic [63:0] chain_reg [8];
    logic [63:0] var_reg [8];
    logic [63:0] bytes_reg;
    logic [3:0]  slot_reg;
    logic [6:0]  round_reg;
    logic [7:0]  pos_reg;   // pad position in bytes, 0..128

    // clamped valid count and masked last word
    logic [3:0]  vb;
    logic [63:0] masked;
    logic [7:0]  pos_calc;
    always_comb
    begin
        vb = (valid_bytes > 4'd8) ? 4'd8 : valid_bytes;
        masked = (vb == 4'd0) ? 64'd0 :
                 message_word & ~(64'hffffffffffffffff >> {vb[3:0], 3'b000});
        if (vb == 4'd8)
            masked = message_word;
        pos_calc = {1'b0, slot_reg, 3'b000} + {4'd0, vb};
    end

    // schedule word for this round
    logic [63:0] w2, w15, s0, s1, wr;
    always_comb
    begin
        w2  = win_reg[14];
        w15 = win_reg[1];
        s1 = {w2[18:0], w2[63:19]} ^ {w2[60:0], w2[63:61]} ^ (w2 >> 6);
        s0 = {w15[0], w15[63:1]} ^ {w15[7:0], w15[63:8]} ^ (w15 >> 7);
        wr = (round_reg < 7'd16) ? win_reg[0] : s1 + win_reg[9] + s0 + win_reg[0];
    end

    // round function
    logic [63:0] t0, t1, e, a;
    always_comb
    begin
        e = var_reg[4];
        a = var_reg[0];
        t0 = var_reg[7] + ({e[13:0], e[63:14]} ^ {e[17:0], e[63:18]} ^ {e[40:0], e[63:41]})
           + (var_reg[6] ^ (e & (var_reg[5] ^ var_reg[6]))) + ROUND_K[round_reg] + wr;
        t1 = ({a[27:0], a[63:28]} ^ {a[33:0], a[63:34]} ^ {a[38:0], a[63:39]})
           + ((a & var_reg[1]) | (var_reg[2] & (a | var_reg[1])));
    end

    // window: shifts one place each round, oldest word at index 0
    always_ff @(posedge clk)
    begin
        if (cmd.do_round)
        begin
            for (int i = 0; i < 15; i++)
                win_reg[i] <= win_reg[i+1];
            win_reg[15] <= wr;
        end
        else if (cmd.clear_win)
        begin
            for (int i = 0; i < 16; i++)
                win_reg[i] <= 64'd0;
        end
        else if (cmd.store_word)
            win_reg[slot_reg] <= message_word;
        else if (cmd.pad_last)
        begin
            for (int i = 0; i < 16; i++)
                if (4'(i) > slot_reg)
                    win_reg[i] <= 64'd0;
            win_reg[slot_reg] <= masked;
        end
        else if (cmd.pad_marker)
            win_reg[pos_reg[6:3]] <= win_reg[pos_reg[6:3]]
                                    | (64'h80 << {3'd7 - pos_reg[2:0], 3'b000});
        else if (cmd.write_len)
        begin
            win_reg[14] <= 64'd0;
            win_reg[15] <= {bytes_reg[60:0], 3'b000};
        end
    end

    // control registers of the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_reg <= 64'd0;
            slot_reg  <= 4'd0;
            round_reg <= 7'd0;
            pos_reg   <= 8'd0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= INIT_H[i];
                var_reg[i]   <= 64'd0;
            end
        end
        else
        begin
            if (cmd.store_word)
            begin
                bytes_reg <= bytes_reg + 64'd8;
                slot_reg  <= slot_reg + 4'd1;
            end
            if (cmd.pad_last)
            begin
                bytes_reg <= bytes_reg + {60'd0, vb};
                pos_reg   <= pos_calc;
            end
            // a cleared window starts a fresh padding block at position zero
            if (cmd.clear_win)
                pos_reg <= 8'd0;
            if (cmd.load_vars)
                for (int i = 0; i < 8; i++)
                    var_reg[i] <= chain_reg[i];
            if (cmd.do_round)
            begin
                round_reg <= (round_reg == LAST_ROUND) ? 7'd0 : round_reg + 7'd1;
                var_reg[7] <= var_reg[6];
                var_reg[6] <= var_reg[5];
                var_reg[5] <= var_reg[4];
                var_reg[4] <= var_reg[3] + t0;
                var_reg[3] <= var_reg[2];
                var_reg[2] <= var_reg[1];
                var_reg[1] <= var_reg[0];
                var_reg[0] <= t0 + t1;
            end
            if (cmd.add_chain)
                for (int i = 0; i < 8; i++)
                    chain_reg[i] <= chain_reg[i] + var_reg[i];
            if (cmd.reload)
            begin
                bytes_reg <= 64'd0;
                slot_reg  <= 4'd0;
                for (int i = 0; i < 8; i++)
                    chain_reg[i] <= INIT_H[i];
            end
        end
    end

    // status back to the controller
    always_comb
    begin
        stat.block_full = (slot_reg == 4'd0);
        stat.last_round = (round_reg == LAST_ROUND);
        stat.pad_over   = pos_reg[7];
        stat.need_extra = (pos_reg > 8'd111);
        digest_word     = chain_reg[emit_index];
    end
endmodule

@@ rtl/core/shc_control.sv @@
// controller: sequences padding, compressions and digest output
// depends on shc_pkg
module shc_control (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_last,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        emit_index,
    output shc_pkg::shc_cmd_t cmd,
    input  shc_pkg::shc_stat_t stat
);
    import shc_pkg::*;

    shc_state_t state_reg, state_next;
    shc_phase_t phase_reg, phase_next;
    logic [2:0] idx_reg, idx_next;
    logic       accept, store_fire;
    logic       from_round;

    assign accept     = in_valid && in_ready;
    assign store_fire = accept && !in_last;

    // next state
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_last)
                begin
                    state_next = ST_ADD;
                    phase_next = PH_AFTER_PAD;
                end
            end
            ST_ROUND:
                if (stat.last_round)
                    state_next = ST_ADD;
            ST_ADD:
            begin
                // ST_ADD also serves as a decision step when entered from idle
                state_next = ST_IDLE;
                case (phase_reg)
                    PH_NONE:       state_next = ST_IDLE;
                    PH_AFTER_PAD:
                    begin
                        if (stat.pad_over)
                        begin
                            state_next = ST_ROUND;
                            phase_next = PH_MARKER;
                        end
                        else
                        begin
                            state_next = ST_ADD;
                            phase_next = PH_MARKER;
                        end
                    end
                    PH_MARKER:
                    begin
                        // after a full data block the window is cleared first, marker next
                        state_next = ST_ADD;
                        phase_next = from_round ? PH_MARKER : PH_AFTER_MARK;
                    end
                    PH_AFTER_MARK:
                    begin
                        state_next = ST_ROUND;
                        phase_next = stat.need_extra ? PH_EXTRA : PH_FINAL;
                    end
                    PH_EXTRA:
                    begin
                        state_next = ST_ADD;
                        phase_next = PH_AFTER_MARK;
                    end
                    PH_FINAL:
                    begin
                        state_next = ST_EMIT;
                        idx_next   = 3'd0;
                    end
                    default:       state_next = ST_IDLE;
                endcase
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        state_next = ST_IDLE;
                        phase_next = PH_NONE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (state_reg == ST_IDLE && store_fire && stat.block_full == 1'b0)
            state_next = ST_IDLE;
    end

    // a full block starts compression once pend_reg records the sixteenth word
    logic pend_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_NONE;
            idx_reg   <= 3'd0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            pend_reg <= store_fire;
            if (state_reg == ST_IDLE && pend_reg && stat.block_full)
            begin
                state_reg <= ST_ROUND;
                phase_reg <= PH_NONE;
            end
            else if (state_reg == ST_ADD && phase_reg == PH_NONE && !stat.last_round
                     && pend_reg == 1'b0 && state_next == ST_IDLE)
                state_reg <= ST_IDLE;
            else
            begin
                state_reg <= state_next;
                phase_reg <= phase_next;
            end
            idx_reg <= idx_next;
        end
    end

    // outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            from_round <= 1'b0;
        else
            from_round <= (state_reg == ST_ROUND) && stat.last_round;
    end

    always_comb
    begin
        cmd        = '0;
        in_ready   = (state_reg == ST_IDLE) && !pend_reg;
        out_valid  = (state_reg == ST_EMIT);
        emit_index = idx_reg;
        cmd.store_word = store_fire;
        cmd.pad_last   = accept && in_last;
        if (state_reg == ST_IDLE && pend_reg && stat.block_full)
            cmd.load_vars = 1'b1;
        if (state_reg == ST_ROUND)
            cmd.do_round = 1'b1;
        if (state_reg == ST_ADD)
        begin
            if (from_round)
                cmd.add_chain = 1'b1;
            case (phase_reg)
                PH_AFTER_PAD:  cmd.load_vars  = stat.pad_over;
                PH_MARKER:
                begin
                    cmd.clear_win  = from_round;
                    cmd.pad_marker = !from_round;
                end
                PH_AFTER_MARK:
                begin
                    cmd.load_vars = 1'b1;
                    cmd.write_len = !stat.need_extra;
                end
                PH_EXTRA:      cmd.clear_win = 1'b1;
                default:       cmd.load_vars = 1'b0;
            endcase
        end
        if (state_reg == ST_EMIT && out_ready && idx_reg == 3'd7)
            cmd.reload = 1'b1;
    end
endmodule

@@ rtl/core/sha512_hash_core_unit.sv @@
// streaming sha-512 core: one message word per item, eight digest items per message
// non-last word: accepted, then ready drops while it is recorded; a full block adds
// a start step, 80 rounds and an add step before further words are taken
// last word: digest items follow one compression, or two with a second block
// reset (rst_n low, asynchronous) restores initial hash values and clears counters
// depends on shc_pkg, shc_if, shc_control, shc_datapath
module sha512_hash_core_unit (
    input  logic   clk,
    input  logic   rst_n,
    shc_msg_if.sink   msg,
    shc_dig_if.source dig
);
    import shc_pkg::*;

    shc_cmd_t   cmd;
    shc_stat_t  stat;
    logic [2:0] emit_index;

    shc_control u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (msg.valid),
        .in_last    (msg.last_word),
        .in_ready   (msg.ready),
        .out_valid  (dig.valid),
        .out_ready  (dig.ready),
        .emit_index (emit_index),
        .cmd        (cmd),
        .stat       (stat)
    );

    shc_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .message_word (msg.message_word),
        .valid_bytes  (msg.valid_bytes),
        .emit_index   (emit_index),
        .digest_word  (dig.digest_word)
    );

    assign dig.word_index  = emit_index;
    assign dig.digest_done = (emit_index == 3'd7);
endmodule

@@ rtl/core/shc_checker.sv @@
// port-level checks for the sha-512 core, bound to the top level
// depends on shc_if
module shc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  word_index,
    input logic        digest_done
);
    // no input taken while digest items are pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input ready during output");

    // done marks only the eighth item
    a_done_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (digest_done == (word_index == 3'd7))) else $error("done mismatch");

    // index steps by one after each taken item but the eighth
    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && word_index != 3'd7) |=> (out_valid
        && word_index == $past(word_index) + 3'd1)) else $error("index step");

    // stalled output holds its index
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(word_index)))
        else $error("stall not held");
endmodule

bind sha512_hash_core_unit shc_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (msg.valid),
    .in_ready    (msg.ready),
    .out_valid   (dig.valid),
    .out_ready   (dig.ready),
    .word_index  (dig.word_index),
    .digest_done (dig.digest_done)
);

@@ tb/sv/tb_sha512_hash_core_unit.sv @@
// testbench for the streaming sha-512 core: drives message words, checks digest items
// depends on shc_pkg, shc_if and the sha512_hash_core_unit rtl
`timescale 1ns / 1ps

module tb_sha512_hash_core_unit;
    import shc_pkg::*;

    typedef struct {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        last;
        logic        has_gold;   // first digest word typed in
        logic [63:0] gold_h0;
    } msg_row_t;

    typedef struct {
        logic [63:0] digest_word;
        logic [2:0]  word_index;
        logic        digest_done;
    } dig_item_t;

    logic clk;
    logic rst_n;

    shc_msg_if msg ();
    shc_dig_if dig ();

    sha512_hash_core_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg.sink),
        .dig   (dig.source)
    );

    // predictor state
    logic [63:0] hash_state [8];
    logic [63:0] block_words [16];
    logic [63:0] msg_bytes;
    int unsigned fill_slot;

    dig_item_t   digest_queue [$];
    logic [63:0] gold_queue [$];
    logic        gold_valid_queue [$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          words_sent;

    function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    // one 80-round compression folded into hash_state
    task automatic compress_block();
        logic [63:0] w [16];
        logic [63:0] v [8];
        logic [63:0] wr, t0, t1, a, b;
        for (int j = 0; j < 16; j++)
            w[j] = block_words[j];
        for (int j = 0; j < 8; j++)
            v[j] = hash_state[j];
        for (int r = 0; r < 80; r++)
        begin
            if (r < 16)
                wr = w[r];
            else
            begin
                a  = w[(r - 2) & 15];
                b  = w[(r - 15) & 15];
                wr = (ror64(a, 19) ^ ror64(a, 61) ^ (a >> 6)) + w[(r - 7) & 15]
                   + (ror64(b, 1) ^ ror64(b, 8) ^ (b >> 7)) + w[r & 15];
                w[r & 15] = wr;
            end
            t0 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
               + (v[6] ^ (v[4] & (v[5] ^ v[6]))) + ROUND_K[r] + wr;
            t1 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
               + ((v[0] & v[1]) | (v[2] & (v[0] | v[1])));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t0;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t0 + t1;
        end
        for (int j = 0; j < 8; j++)
            hash_state[j] += v[j];
    endtask

    task automatic restart_hash();
        for (int j = 0; j < 8; j++)
            hash_state[j] = INIT_H[j];
        msg_bytes = '0;
        fill_slot = 0;
    endtask

    // absorb one accepted word, queue the digest items it causes
    task automatic absorb_word(input logic [63:0] word_in, input logic [3:0] nb_in,
                               input logic last, input logic has_gold,
                               input logic [63:0] gold);
        logic [63:0] word;
        int unsigned nb, pos;
        dig_item_t   item;
        word = word_in;
        if (!last)
        begin
            block_words[fill_slot] = word;
            msg_bytes += 8;
            fill_slot++;
            if (fill_slot == 16)
            begin
                compress_block();
                fill_slot = 0;
            end
        end
        else
        begin
            nb = (nb_in > 8) ? 8 : nb_in;
            if (nb == 0)
                word = '0;
            else if (nb < 8)
                word &= ~64'd0 << (64 - 8 * nb);
            msg_bytes += nb;
            block_words[fill_slot] = word;
            for (int j = fill_slot + 1; j < 16; j++)
                block_words[j] = '0;
            pos = fill_slot * 8 + nb;
            if (pos >= 128)
            begin
                compress_block();
                for (int j = 0; j < 16; j++)
                    block_words[j] = '0;
                pos = 0;
            end
            block_words[(pos >> 3) & 15] |= 64'h80 << (56 - 8 * (pos & 7));
            if (pos + 1 > 112)
            begin
                compress_block();
                for (int j = 0; j < 16; j++)
                    block_words[j] = '0;
            end
            block_words[14] = '0;
            block_words[15] = msg_bytes << 3;
            compress_block();
            for (int j = 0; j < 8; j++)
            begin
                item.digest_word = hash_state[j];
                item.word_index  = 3'(j);
                item.digest_done = (j == 7);
                digest_queue.push_back(item);
                gold_valid_queue.push_back(has_gold && j == 0);
                gold_queue.push_back(gold);
            end
            restart_hash();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hard limit on run time
    initial
    begin
        #40000000;
        $display("sha512_hash_core_unit regression: fail");
        $finish;
    end

    // digest side: random stall and checking
    always @(posedge clk)
    begin
        dig_item_t want;
        if (rst_n && dig.valid && dig.ready)
        begin
            if (digest_queue.size() == 0)
                report_mismatch("unexpected digest item", dig.digest_word, '0);
            else
            begin
                want = digest_queue.pop_front();
                if (gold_valid_queue.pop_front() && dig.digest_word !== gold_queue[0])
                    report_mismatch("known digest", dig.digest_word, gold_queue[0]);
                void'(gold_queue.pop_front());
                if (dig.digest_word !== want.digest_word)
                    report_mismatch("digest_word", dig.digest_word, want.digest_word);
                if (dig.word_index !== want.word_index)
                    report_mismatch("word_index", 64'(dig.word_index),
                                    64'(want.word_index));
                if (dig.digest_done !== want.digest_done)
                    report_mismatch("digest_done", 64'(dig.digest_done),
                                    64'(want.digest_done));
            end
        end
        dig.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // drive one word and wait for acceptance
    task automatic send_word(input logic [63:0] w, input logic [3:0] nb, input logic last,
                             input logic has_gold, input logic [63:0] gold);
        while ($urandom_range(99) < send_idle_pct)
        begin
            msg.valid <= 1'b0;
            @(posedge clk);
        end
        msg.valid        <= 1'b1;
        msg.message_word <= w;
        msg.valid_bytes  <= nb;
        msg.last_word    <= last;
        @(posedge clk);
        while (!msg.ready)
            @(posedge clk);
        absorb_word(w, nb, last, has_gold, gold);
        words_sent++;
    endtask

    task automatic drain_digests();
        msg.valid <= 1'b0;
        while (digest_queue.size() != 0)
            @(posedge clk);
    endtask

    // random message: mostly short, a few spanning several blocks
    task automatic random_message();
        int unsigned len;
        logic [63:0] w;
        len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(17);
        for (int k = 0; k < len; k++)
        begin
            w = {$urandom, $urandom};
            send_word(w, 4'($urandom_range(15)), 1'b0, 1'b0, '0);
        end
        w = {$urandom, $urandom};
        send_word(w, 4'($urandom_range(15)), 1'b1, 1'b0, '0);
    endtask

    msg_row_t directed [$];

    initial
    begin
        msg_row_t row;
        int start_count;
        mismatches     = 0;
        words_sent     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n            = 1'b0;
        msg.valid        = 1'b0;
        msg.message_word = '0;
        msg.valid_bytes  = '0;
        msg.last_word    = 1'b0;
        restart_hash();
        for (int j = 0; j < 16; j++)
            block_words[j] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: empty message, "abc", counts above eight, full-block boundaries
        directed.push_back('{64'hffff_ffff_ffff_ffff, 4'd0, 1'b1, 1'b1,
                             64'hcf83e1357eefb8bd});
        directed.push_back('{64'h6162_63ff_ffff_ffff, 4'd3, 1'b1, 1'b1,
                             64'hddaf35a193617aba});
        directed.push_back('{64'hffff_ffff_ffff_ffff, 4'd15, 1'b1, 1'b0, '0});
        directed.push_back('{64'h0, 4'd9, 1'b1, 1'b0, '0});
        directed.push_back('{64'h0123_4567_89ab_cdef, 4'd8, 1'b1, 1'b0, '0});
        // thirteen full words then eight bytes: marker crosses 112, extra block
        for (int k = 0; k < 13; k++)
            directed.push_back('{64'h8000_0000_0000_0001 ^ k, 4'd15, 1'b0, 1'b0, '0});
        directed.push_back('{64'ha5a5_5a5a_ffff_0000, 4'd8, 1'b1, 1'b0, '0});
        // fifteen words plus eight bytes: pad position reaches 128
        for (int k = 0; k < 15; k++)
            directed.push_back('{~64'(k), 4'd0, 1'b0, 1'b0, '0});
        directed.push_back('{64'h1234_5678_9abc_def0, 4'd8, 1'b1, 1'b0, '0});
        foreach (directed[i])
        begin
            row = directed[i];
            send_word(row.word, row.nbytes, row.last, row.has_gold, row.gold_h0);
        end
        drain_digests();

        // random phases with varied idling and stalling, about 94 words each
        start_count = words_sent;
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 3) ? 35 : 62) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 35 : 62) : 0;
            while (words_sent < start_count + (phase + 1) * 94)
            begin
                random_message();
                if ($urandom_range(7) == 0)
                    drain_digests();
            end
            drain_digests();
        end

        drain_digests();
        repeat (200) @(posedge clk);
        if (mismatches == 0 && digest_queue.size() == 0)
            $display("sha512_hash_core_unit regression: pass");
        else
            $display("sha512_hash_core_unit regression: fail");
        $finish;
    end

endmodule
